/* design/swz_pkg.sv */
`default_nettype none

package swz_pkg;

	// Defaults for the top-level parameters
	localparam int CHUNK_SIZE_DEF = 128;
	localparam int MAX_SIDE_DEF   = 4096;

	// Configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_W-1:0]     IMAGE_SIDE_RST   = 13'd128;

	// Field widths
	localparam int CHUNK_W  = 10;
	localparam int OFFSET_W = 14;
	localparam int COLOR_W  = 16;

	// Positions inside a chunk texture: columns up to 1023 plus 63 padding
	localparam int POS_W   = 11;
	localparam int LG_W    = 4;
	localparam int LG_MIN  = 3;
	localparam int LG_MAX  = 10;
	localparam int PAD_W   = 6;
	localparam logic [PAD_W-1:0] PAD_MAX = 6'd63;

	// Descriptor queue
	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic [POS_W-1:0]   xin;
		logic [POS_W-1:0]   yin;
		logic [POS_W-1:0]   chunk_w;
		logic [LG_W-1:0]    tex_lg;
		logic [PAD_W-1:0]   pad_n;
		logic [COLOR_W-1:0] color;
		logic               image_end;
	} swz_desc_t;

	// Smallest power-of-two exponent, at least LG_MIN, covering the chunk width
	function automatic logic [LG_W-1:0] tex_log2(input logic [POS_W-1:0] cw);
		logic [LG_W-1:0] lg;
		lg = LG_W'(LG_MAX);
		for (int j = LG_MAX; j >= LG_MIN; j--) begin
			if ((POS_W+1)'(1 << j) >= {1'b0, cw})
				lg = LG_W'(j);
		end
		return lg;
	endfunction

	// Spread three bits onto the even positions of six
	function automatic logic [5:0] spread3(input logic [2:0] v);
		logic [15:0] s;
		s = {13'd0, v};
		s = (s | (s << 4)) & 16'h0F0F;
		s = (s | (s << 2)) & 16'h3333;
		s = (s | (s << 1)) & 16'h5555;
		return s[5:0];
	endfunction

	// Tile index times 64 plus the Morton order inside an 8x8 tile
	function automatic logic [OFFSET_W-1:0] tiled_offset(input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [LG_W-1:0] lg);
		logic [OFFSET_W-1:0] tile;
		logic [5:0]          inner;
		tile  = (OFFSET_W'(y >> 3) << (lg - LG_W'(LG_MIN))) + OFFSET_W'(x >> 3);
		inner = spread3(x[2:0]) | (spread3(y[2:0]) << 1);
		return {tile[OFFSET_W-7:0], inner};
	endfunction

endpackage

`default_nettype wire

/* design/swz_pixel_if.sv */
`default_nettype none

interface swz_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

/* design/swz_texel_if.sv */
`default_nettype none

interface swz_texel_if;
	logic        valid;
	logic        ready;
	logic [9:0]  chunk_index;
	logic [13:0] texel_offset;
	logic [15:0] texel_color;
	logic        is_padding;
	logic        run_last;
	logic        image_end;

	modport source (output valid, chunk_index, texel_offset, texel_color, is_padding,
		run_last, image_end, input ready);
	modport sink   (input valid, chunk_index, texel_offset, texel_color, is_padding,
		run_last, image_end, output ready);
endinterface

`default_nettype wire

/* design/morton_tiled_texture_swizzler.sv */
`default_nettype none

// Channel | Direction | Payload                                   | Beat
// pixel   | in        | red, green, blue                          | one raster pixel
// texel   | out       | chunk_index, texel_offset, texel_color,   | one texture write
//         |           | is_padding, run_last, image_end           |
// cfg     | in        | cfg_index, cfg_data (write on cfg_we)     | one register write
//
// Cycles: one pixel per cycle while the queue has room. A pixel that closes a chunk
//   row of a chunk whose width is not a power of two (or below 8) gives 1 + pad
//   beats, pad = texture width minus chunk width, at most 63; the back end's counter
//   emits one beat per cycle while texel.ready is high; that pixel holds the port.
// Path: a pixel beat passes the queue, then the output register, to its first texel beat.
// Reset: counters to the first pixel, width and height to 128, queue empty.
// Stalls: the four-entry queue lets the pixel side keep going while texel.ready is
//   low or a padding run drains; pixel.ready drops only when the queue is full.

module morton_tiled_texture_swizzler
	import swz_pkg::*;
#(
	parameter int CHUNK_SIZE = CHUNK_SIZE_DEF,
	parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	swz_pixel_if.sink                 pixel,
	swz_texel_if.source               texel
);

	// Front to queue
	logic      push_valid, push_ready;
	swz_desc_t push_desc;
	// Queue to back
	logic      head_valid, pop;
	swz_desc_t head;

	// Front: track raster position, classify the pixel (chunk, inner position,
	// texture width, padding run length) and pack its colour.
	swz_front #(
		.CHUNK_SIZE(CHUNK_SIZE),
		.MAX_SIDE  (MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc (push_desc)
	);

	// Queue: decouple pixel intake from write emission.
	swz_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc (push_desc),
		.pop_valid (head_valid),
		.pop       (pop),
		.pop_desc  (head)
	);

	// Back: expand each descriptor into the pixel write and its padding writes,
	// compute the tiled offset and hold each beat in the output register.
	swz_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.texel     (texel)
	);

endmodule

`default_nettype wire

/* design/swz_front.sv */
`default_nettype none

module swz_front
	import swz_pkg::*;
#(
	parameter int CHUNK_SIZE = CHUNK_SIZE_DEF,
	parameter int MAX_SIDE   = MAX_SIDE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	swz_pixel_if.sink                 pixel,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output swz_desc_t                 push_desc
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int XIN_W  = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
	localparam int CW1    = $clog2(CHUNK_SIZE + 1);
	localparam int CMP_A  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
	localparam int CMP_W  = ((CMP_A > CW1) ? CMP_A : CW1) + 1;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [SIDE_W-1:0]  x_q, y_q, cx_base_q;
	logic [XIN_W-1:0]   xin_q, yin_q;
	logic [CHUNK_W-1:0] cx_q, row_base_q;

	logic [SIDE_W-1:0]  w_eff, h_eff;
	logic [CMP_W-1:0]   rem;
	logic [POS_W-1:0]   chunk_w, xin_ext, tex_w, pad_full;
	logic [LG_W-1:0]    tex_lg;
	logic [PAD_W-1:0]   pad_n;
	logic               row_end, img_end, accept, cfg_hit;

	// Zero reads as one, oversize clamps to the largest side
	always_comb begin
		if (width_q == '0)
			w_eff = SIDE_W'(1);
		else if (CMP_W'(width_q) > CMP_W'(MAX_SIDE))
			w_eff = SIDE_W'(MAX_SIDE);
		else
			w_eff = SIDE_W'(width_q);
		if (height_q == '0)
			h_eff = SIDE_W'(1);
		else if (CMP_W'(height_q) > CMP_W'(MAX_SIDE))
			h_eff = SIDE_W'(MAX_SIDE);
		else
			h_eff = SIDE_W'(height_q);
	end

	always_comb begin
		rem      = CMP_W'(w_eff) - CMP_W'(cx_base_q);
		chunk_w  = (rem >= CMP_W'(CHUNK_SIZE)) ? POS_W'(CHUNK_SIZE) : POS_W'(rem);
		tex_lg   = tex_log2(chunk_w);
		tex_w    = POS_W'(1) << tex_lg;
		xin_ext  = POS_W'(xin_q);
		pad_full = tex_w - chunk_w;
		pad_n    = '0;
		if (xin_ext == chunk_w - POS_W'(1))
			pad_n = (pad_full > POS_W'(PAD_MAX)) ? PAD_MAX : pad_full[PAD_W-1:0];
		row_end  = (x_q == w_eff - SIDE_W'(1));
		img_end  = row_end && (y_q == h_eff - SIDE_W'(1));
	end

	assign push_valid = pixel.valid;
	assign pixel.ready = push_ready;
	assign accept = pixel.valid && push_ready;

	always_comb begin
		push_desc.chunk     = row_base_q + cx_q;
		push_desc.xin       = xin_ext;
		push_desc.yin       = POS_W'(yin_q);
		push_desc.chunk_w   = chunk_w;
		push_desc.tex_lg    = tex_lg;
		push_desc.pad_n     = pad_n;
		push_desc.color     = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};
		push_desc.image_end = img_end;
	end

	always_comb begin
		unique case (cfg_index) inside
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_SIDE_RST;
			height_q <= IMAGE_SIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raster position, split into chunk base and offset inside the chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			cx_base_q  <= '0;
			xin_q      <= '0;
			yin_q      <= '0;
			cx_q       <= '0;
			row_base_q <= '0;
		end else if (cfg_hit) begin
			x_q        <= '0;
			y_q        <= '0;
			cx_base_q  <= '0;
			xin_q      <= '0;
			yin_q      <= '0;
			cx_q       <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				x_q       <= '0;
				cx_base_q <= '0;
				xin_q     <= '0;
				cx_q      <= '0;
				if (img_end) begin
					y_q        <= '0;
					yin_q      <= '0;
					row_base_q <= '0;
				end else begin
					y_q <= y_q + SIDE_W'(1);
					if (yin_q == XIN_W'(CHUNK_SIZE - 1)) begin
						yin_q      <= '0;
						row_base_q <= row_base_q + cx_q + CHUNK_W'(1);
					end else begin
						yin_q <= yin_q + XIN_W'(1);
					end
				end
			end else begin
				x_q <= x_q + SIDE_W'(1);
				if (xin_q == XIN_W'(CHUNK_SIZE - 1)) begin
					xin_q     <= '0;
					cx_base_q <= cx_base_q + SIDE_W'(CHUNK_SIZE);
					cx_q      <= cx_q + CHUNK_W'(1);
				end else begin
					xin_q <= xin_q + XIN_W'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_x_in_image: assert property (@(posedge clk) disable iff (!arst_n) x_q < w_eff)
		else $error("column counter beyond image width");
	a_y_in_image: assert property (@(posedge clk) disable iff (!arst_n) y_q < h_eff)
		else $error("row counter beyond image height");
	a_base_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cx_base_q) + CMP_W'(xin_q) == CMP_W'(x_q))
		else $error("chunk base and inner column disagree with column");
`endif

endmodule

`default_nettype wire

/* design/swz_queue.sv */
`default_nettype none

module swz_queue
	import swz_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire swz_desc_t  push_desc,
	output logic            pop_valid,
	input  wire logic       pop,
	output swz_desc_t       pop_desc
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	swz_desc_t        mem [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* design/swz_back.sv */
`default_nettype none

module swz_back
	import swz_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire swz_desc_t head,
	output logic           pop,
	swz_texel_if.source    texel
);

	logic [PAD_W-1:0] idx_q;
	logic             out_valid_q;
	logic             load, beat_last;
	logic [POS_W-1:0] xpos;

	assign load      = head_valid && (!out_valid_q || texel.ready);
	assign beat_last = (idx_q == head.pad_n);
	assign pop       = load && beat_last;

	// Pixel beat first, then padding columns right of the chunk
	assign xpos = (idx_q == '0) ? head.xin
		: head.chunk_w + POS_W'(idx_q) - POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (texel.ready)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= beat_last ? '0 : idx_q + PAD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			texel.chunk_index  <= head.chunk;
			texel.texel_offset <= tiled_offset(xpos, head.yin, head.tex_lg);
			texel.texel_color  <= (idx_q == '0) ? head.color : '0;
			texel.is_padding   <= (idx_q != '0);
			texel.run_last     <= beat_last;
			texel.image_end    <= head.image_end;
		end
	end

	assign texel.valid = out_valid_q;

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.pad_n)
		else $error("padding counter past the run length");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == '0)
		else $error("padding counter left mid-run with no descriptor");
	a_pad_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && texel.is_padding |-> texel.texel_color == '0)
		else $error("padding write carries a colour");
`endif

endmodule

`default_nettype wire
